/* rtl/c8008_pkg.sv */
// Shared types and constants for the 8008 instruction step core.
package c8008_pkg;

    localparam int unsigned REG_A = 0;
    localparam int unsigned REG_H = 5;
    localparam int unsigned REG_L = 6;
    localparam int unsigned REG_M = 7;
    localparam logic [15:0] FRAME_RESET = 16'd256;

    // One beat as it travels from the front part through the queue.
    typedef struct packed {
        logic       command;
        logic [7:0] opcode;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] memory_at_hl;
        logic [7:0] io_return;
        logic [7:0] interrupt_vector;
        logic [1:0] length;
        logic       is_halt_op;
    } t_item;

    function automatic logic [1:0] instr_length(input logic [7:0] op);
        logic [4:0] cls;
        cls = {op[7:6], op[2:0]};
        if (cls == 5'd4 || cls == 5'd6) begin
            instr_length = 2'd2;
        end else if ((cls & 5'h19) == 5'h08) begin
            instr_length = 2'd3;
        end else begin
            instr_length = 2'd1;
        end
    endfunction

endpackage

/* rtl/c8008_front.sv */
// Front part: takes input beats, classifies them and holds a two-entry queue.
module c8008_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  c8008_pkg::t_item      i_item,
    output logic                  o_q_valid,
    output c8008_pkg::t_item      o_q_item,
    input  logic                  i_q_pop
);
    c8008_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;
    c8008_pkg::t_item cls_item;

    always_comb begin
        cls_item = i_item;
        cls_item.length = c8008_pkg::instr_length(i_item.opcode);
        cls_item.is_halt_op = (i_item.opcode < 8'd2) || (i_item.opcode == 8'hFF);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

/* rtl/c8008_back.sv */
// Back part: executes one queued instruction per cycle, while the output register is empty or being taken.
module c8008_back #(
    parameter int unsigned STACK_DEPTH  = 8,
    parameter int unsigned ADDRESS_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_q_valid,
    input  c8008_pkg::t_item        i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [13:0]             o_next_pc,
    output logic [13:0]             o_hl_address,
    output logic                    o_mem_write,
    output logic [13:0]             o_mem_write_address,
    output logic [7:0]              o_mem_write_data,
    output logic                    o_io_access,
    output logic [4:0]              o_io_port,
    output logic [7:0]              o_io_out_data,
    output logic [1:0]              o_bytes_used,
    output logic                    o_halted,
    output logic                    o_frame_end
);
    localparam int unsigned SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);
    localparam logic [15:0] ADDR_MASK = 16'((1 << ADDRESS_BITS) - 1);

    logic [7:0]              r_regs [8];
    logic [ADDRESS_BITS-1:0] r_stack [STACK_DEPTH];
    logic                    r_carry, r_halt, r_valid;
    logic [7:0]              r_flag;
    logic [SPW-1:0]          r_sp;
    logic [15:0]             r_cyc, r_frame;

    logic [7:0]              n_regs [8];
    logic                    n_carry, n_halt;
    logic [7:0]              n_flag;
    logic [SPW-1:0]          n_sp;
    logic [15:0]             n_cyc;
    logic                    stk_we, adv_we;
    logic [SPW-1:0]          stk_wa;
    logic [ADDRESS_BITS-1:0] stk_wd, n_pc, pc_adv;
    logic                    n_mw, n_io, n_fe;
    logic [13:0]             n_mwa;
    logic [7:0]              n_mwd, n_iod;
    logic [4:0]              n_port;
    logic [1:0]              n_len;

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;

    function automatic logic [SPW-1:0] sp_inc(input logic [SPW-1:0] s);
        sp_inc = (s == SP_LAST) ? '0 : s + 1'b1;
    endfunction
    function automatic logic [SPW-1:0] sp_dec(input logic [SPW-1:0] s);
        sp_dec = (s == '0) ? SP_LAST : s - 1'b1;
    endfunction

    always_comb begin
        logic [7:0] op, a, opnd, res;
        logic [8:0] sum;
        logic [4:0] cls;
        logic [2:0] f, rd;
        logic       cond, p;
        logic [4:0] cost;
        logic [15:0] hl;
        logic [16:0] cnt;
        op = i_q_item.opcode;
        cls = {op[7:6], op[2:0]};
        rd = op[5:3];
        f = op[5:3];
        for (int i = 0; i < 8; i++) n_regs[i] = r_regs[i];
        n_carry = r_carry; n_halt = r_halt; n_flag = r_flag; n_sp = r_sp; n_cyc = r_cyc;
        stk_we = 1'b0; stk_wa = r_sp; stk_wd = '0; adv_we = 1'b0;
        n_mw = 1'b0; n_mwa = '0; n_mwd = '0; n_io = 1'b0; n_port = '0; n_iod = '0;
        n_len = '0; n_fe = 1'b0; cost = '0;
        a = r_regs[c8008_pkg::REG_A];
        opnd = 8'h00; res = 8'h00; sum = 9'h000;
        case (op[4:3])
            2'd0: p = r_carry;
            2'd1: p = (r_flag == 8'h00);
            2'd2: p = r_flag[7];
            default: p = ~^r_flag;
        endcase
        cond = op[5] ? p : ~p;
        pc_adv = r_stack[r_sp] + ADDRESS_BITS'(i_q_item.length);
        hl = {r_regs[c8008_pkg::REG_H], r_regs[c8008_pkg::REG_L]} & ADDR_MASK;
        cnt = '0;
        if (i_q_item.command) begin
            n_halt = 1'b0;
            n_sp = sp_inc(r_sp);
            stk_we = 1'b1; stk_wa = n_sp;
            stk_wd = ADDRESS_BITS'(i_q_item.interrupt_vector);
        end else if (r_halt) begin
            n_cyc = '0;
            n_fe = 1'b1;
        end else begin
            n_len = i_q_item.length;
            // The current stack slot always advances past the instruction; a
            // taken jump, call or restart writes its target on top of that.
            adv_we = 1'b1;
            if (i_q_item.is_halt_op) begin
                n_halt = 1'b1;
                cnt = {1'b0, r_frame};
            end else begin
                if (cls == 5'h04 || (cls >= 5'h10 && cls < 5'h18)) begin
                    // ALU group: immediate or register/memory source
                    if (cls == 5'h04) begin
                        opnd = i_q_item.byte_two;
                    end else if (op[2:0] == 3'd7) begin
                        opnd = i_q_item.memory_at_hl;
                    end else begin
                        opnd = r_regs[op[2:0]];
                    end
                    case (f)
                        3'd0: sum = {1'b0, a} + {1'b0, opnd};
                        3'd1: sum = {1'b0, a} + {1'b0, opnd} + {8'h00, r_carry};
                        3'd2, 3'd7: sum = {1'b0, a} - {1'b0, opnd};
                        3'd3: sum = {1'b0, a} - {1'b0, opnd} - {8'h00, r_carry};
                        3'd4: sum = {1'b0, a & opnd};
                        3'd5: sum = {1'b0, a ^ opnd};
                        default: sum = {1'b0, a | opnd};
                    endcase
                    n_carry = sum[8];
                    n_flag = sum[7:0];
                    if (f != 3'd7) n_regs[c8008_pkg::REG_A] = sum[7:0];
                    if (cls[4] && op[2:0] == 3'd7) n_regs[c8008_pkg::REG_M] = i_q_item.memory_at_hl;
                    cost = (cls == 5'h04) ? 5'd8 : 5'd6;
                end else if (cls >= 5'h18) begin
                    opnd = (op[2:0] == 3'd7) ? i_q_item.memory_at_hl : r_regs[op[2:0]];
                    if (op[2:0] == 3'd7) n_regs[c8008_pkg::REG_M] = i_q_item.memory_at_hl;
                    n_regs[rd] = opnd;
                    if (rd == 3'd7) begin
                        n_mw = 1'b1; n_mwa = hl[13:0]; n_mwd = opnd;
                    end
                    cost = 5'd6;
                end else begin
                    case (cls)
                        5'h00, 5'h01: begin
                            res = r_regs[rd] + (op[0] ? 8'hFF : 8'h01);
                            n_regs[rd] = res; n_flag = res; cost = 5'd5;
                        end
                        5'h02: begin
                            case (op)
                                8'h02: begin n_regs[0] = {a[6:0], a[7]}; n_carry = a[7]; end
                                8'h0A: begin n_regs[0] = {a[0], a[7:1]}; n_carry = a[0]; end
                                8'h12: begin n_regs[0] = {a[6:0], r_carry}; n_carry = a[7]; end
                                8'h1A: begin n_regs[0] = {r_carry, a[7:1]}; n_carry = a[0]; end
                                default: ;
                            endcase
                            cost = 5'd5;
                        end
                        5'h03, 5'h07: begin
                            if (cls == 5'h07 || cond) n_sp = sp_dec(r_sp);
                            cost = 5'd4;
                        end
                        5'h05: begin
                            n_sp = sp_inc(r_sp);
                            stk_we = 1'b1;
                            stk_wa = n_sp; stk_wd = ADDRESS_BITS'({op[5:3], 3'b000});
                            cost = 5'd5;
                        end
                        5'h06: begin
                            n_regs[rd] = i_q_item.byte_two;
                            if (rd == 3'd7) begin
                                n_mw = 1'b1; n_mwa = hl[13:0]; n_mwd = i_q_item.byte_two;
                            end
                            cost = 5'd8;
                        end
                        5'h08, 5'h0A, 5'h0C, 5'h0E: begin
                            if (op[2] || cond) begin
                                if (op[1]) n_sp = sp_inc(r_sp);
                                stk_we = 1'b1;
                                stk_wa = n_sp;
                                stk_wd = ADDRESS_BITS'({i_q_item.byte_three, i_q_item.byte_two});
                            end
                            cost = 5'd10;
                        end
                        5'h09, 5'h0B, 5'h0D, 5'h0F: begin
                            n_io = 1'b1; n_port = op[5:1]; n_iod = a;
                            n_regs[0] = i_q_item.io_return;
                            cost = 5'd7;
                        end
                        default: ;
                    endcase
                end
                cnt = {1'b0, r_cyc} + 17'(cost);
                cnt[16] = 1'b0;
            end
            if (cnt[15:0] >= r_frame) begin
                n_cyc = cnt[15:0] - r_frame;
                n_fe = 1'b1;
            end else begin
                n_cyc = cnt[15:0];
            end
        end
        if (stk_we && stk_wa == n_sp) begin
            n_pc = stk_wd;
        end else if (adv_we && r_sp == n_sp) begin
            n_pc = pc_adv;
        end else begin
            n_pc = r_stack[n_sp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (adv_we) r_stack[r_sp] <= pc_adv;
            if (stk_we) r_stack[stk_wa] <= stk_wd;
            o_next_pc           <= 14'(n_pc);
            o_hl_address        <= 14'({n_regs[c8008_pkg::REG_H], n_regs[c8008_pkg::REG_L]}
                                       & ADDR_MASK);
            o_mem_write         <= n_mw;
            o_mem_write_address <= n_mwa & ADDR_MASK[13:0];
            o_mem_write_data    <= n_mwd;
            o_io_access         <= n_io;
            o_io_port           <= n_port;
            o_io_out_data       <= n_iod;
            o_bytes_used        <= n_len;
            o_halted            <= n_halt;
            o_frame_end         <= n_fe;
        end
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_regs[i] <= 8'h00;
            for (int i = 0; i < STACK_DEPTH; i++) r_stack[i] <= '0;
            r_carry <= 1'b0; r_halt <= 1'b0; r_flag <= 8'h00; r_sp <= '0;
            r_cyc <= 16'h0000; r_frame <= c8008_pkg::FRAME_RESET; r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_frame <= i_cfg_data;
            if (o_q_pop) begin
                for (int i = 0; i < 8; i++) r_regs[i] <= n_regs[i];
                r_carry <= n_carry; r_halt <= n_halt; r_flag <= n_flag;
                r_sp <= n_sp; r_cyc <= n_cyc;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule

/* rtl/cpu_8008_instruction_step.sv */
// Top level of the 8008 instruction step core: front queue plus execute back end.
// The core runs one 8008 instruction, or takes one interrupt, per input beat.
// The input channel (i_valid/o_ready) carries the opcode, the two bytes after
// it, the memory byte at HL, the I/O return value and an interrupt vector.
// The output channel (o_valid/i_ready) returns one result beat per input beat:
// next PC, HL, any memory write at HL, any I/O access, the instruction length,
// the halt state and the frame-end flag.
// The front end classifies each beat (length, halt opcode) and places it in
// a two-entry queue. The back end executes the queue head combinationally and
// registers the result as it pops the head, so each beat is held first in a
// queue entry and then in the output register, where o_valid marks it.
// Throughput is one beat per cycle while i_ready stays high; the limit is the
// execute loop through the register file, flags and program-counter stack.
// When the receiver stalls, the output register holds its beat, the back end
// stops draining, and the queue absorbs up to two more beats before o_ready
// falls. Reset clears registers, flags, stack and counters, empties the queue,
// and restores the frame size to 256. i_cfg_we writes the frame size at any
// edge; it is meant to change only while the core is idle.
module cpu_8008_instruction_step #(
    parameter int unsigned STACK_DEPTH  = 8,
    parameter int unsigned ADDRESS_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_byte_two,
    input  logic [7:0]  i_byte_three,
    input  logic [7:0]  i_memory_at_hl,
    input  logic [7:0]  i_io_return,
    input  logic [7:0]  i_interrupt_vector,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [13:0] o_next_pc,
    output logic [13:0] o_hl_address,
    output logic        o_mem_write,
    output logic [13:0] o_mem_write_address,
    output logic [7:0]  o_mem_write_data,
    output logic        o_io_access,
    output logic [4:0]  o_io_port,
    output logic [7:0]  o_io_out_data,
    output logic [1:0]  o_bytes_used,
    output logic        o_halted,
    output logic        o_frame_end
);
    c8008_pkg::t_item in_item, q_item;
    logic q_valid, q_pop;

    // The classification fields are filled in by the front end.
    always_comb begin
        in_item = '0;
        in_item.command          = i_command;
        in_item.opcode           = i_opcode;
        in_item.byte_two         = i_byte_two;
        in_item.byte_three       = i_byte_three;
        in_item.memory_at_hl     = i_memory_at_hl;
        in_item.io_return        = i_io_return;
        in_item.interrupt_vector = i_interrupt_vector;
    end

    c8008_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(in_item),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    c8008_back #(.STACK_DEPTH(STACK_DEPTH), .ADDRESS_BITS(ADDRESS_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_next_pc(o_next_pc), .o_hl_address(o_hl_address),
        .o_mem_write(o_mem_write), .o_mem_write_address(o_mem_write_address),
        .o_mem_write_data(o_mem_write_data), .o_io_access(o_io_access),
        .o_io_port(o_io_port), .o_io_out_data(o_io_out_data),
        .o_bytes_used(o_bytes_used), .o_halted(o_halted), .o_frame_end(o_frame_end)
    );
endmodule

/* verif/tb.sv */
// Self-checking testbench for the 8008 instruction step core.
`timescale 1ns / 100ps

module tb;

    // One instruction or interrupt beat on the input channel.
    typedef struct {
        logic       command;
        logic [7:0] opcode;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] memory_at_hl;
        logic [7:0] io_return;
        logic [7:0] interrupt_vector;
    } t_instr;

    // One result beat, in the order of the output ports.
    typedef struct {
        logic [13:0] next_pc;
        logic [13:0] hl_address;
        logic        mem_write;
        logic [13:0] mem_write_address;
        logic [7:0]  mem_write_data;
        logic        io_access;
        logic [4:0]  io_port;
        logic [7:0]  io_out_data;
        logic [1:0]  bytes_used;
        logic        halted;
        logic        frame_end;
    } t_outcome;

    localparam int unsigned STACK_SLOTS = 8;
    localparam int unsigned CMD_EXECUTE = 0;
    localparam int unsigned CMD_INTERRUPT = 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [7:0]  i_opcode = '0;
    logic [7:0]  i_byte_two = '0;
    logic [7:0]  i_byte_three = '0;
    logic [7:0]  i_memory_at_hl = '0;
    logic [7:0]  i_io_return = '0;
    logic [7:0]  i_interrupt_vector = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [13:0] o_next_pc;
    logic [13:0] o_hl_address;
    logic        o_mem_write;
    logic [13:0] o_mem_write_address;
    logic [7:0]  o_mem_write_data;
    logic        o_io_access;
    logic [4:0]  o_io_port;
    logic [7:0]  o_io_out_data;
    logic [1:0]  o_bytes_used;
    logic        o_halted;
    logic        o_frame_end;

    cpu_8008_instruction_step DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_opcode(i_opcode), .i_byte_two(i_byte_two),
        .i_byte_three(i_byte_three), .i_memory_at_hl(i_memory_at_hl),
        .i_io_return(i_io_return), .i_interrupt_vector(i_interrupt_vector),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_next_pc(o_next_pc), .o_hl_address(o_hl_address),
        .o_mem_write(o_mem_write), .o_mem_write_address(o_mem_write_address),
        .o_mem_write_data(o_mem_write_data), .o_io_access(o_io_access),
        .o_io_port(o_io_port), .o_io_out_data(o_io_out_data),
        .o_bytes_used(o_bytes_used), .o_halted(o_halted), .o_frame_end(o_frame_end)
    );

    always #6 i_clk = ~i_clk;

    // Testbench copy of the core's architectural state.
    logic [7:0]  cpu_regs [8];
    logic        cpu_carry;
    logic [7:0]  cpu_flags;
    logic        cpu_halt;
    logic [13:0] pc_stack [STACK_SLOTS];
    logic [2:0]  stack_top;
    logic [15:0] cycle_count;
    logic [15:0] frame_size;

    t_instr   pending_instrs [$];
    t_outcome expected_outcomes [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned frame_ends = 0;
    int unsigned error_count = 0;

    // The handshake is judged at the rising edge; the driver reads this flag afterward.
    logic o_ready_seen = 1'b0;

    function automatic bit even_parity(input logic [7:0] v);
        return ~^v;
    endfunction

    // The condition field sits in bits 4:3; bit 5 selects true or false sense.
    function automatic bit condition_true(input logic [7:0] op);
        bit p;
        case (op[4:3])
            2'd0: p = cpu_carry;
            2'd1: p = (cpu_flags == 8'h00);
            2'd2: p = cpu_flags[7];
            default: p = even_parity(cpu_flags);
        endcase
        return op[5] ? p : !p;
    endfunction

    function automatic void push_stack();
        stack_top = stack_top + 3'd1;
    endfunction

    function automatic void pop_stack();
        stack_top = stack_top - 3'd1;
    endfunction

    function automatic logic [13:0] hl_pair();
        return {cpu_regs[c8008_pkg::REG_H][5:0], cpu_regs[c8008_pkg::REG_L]};
    endfunction

    // Arithmetic group; compare (function 7) only updates flags and carry.
    function automatic void arith_op(input logic [7:0] op, input logic [7:0] operand);
        logic [8:0] r;
        logic [7:0] a;
        a = cpu_regs[c8008_pkg::REG_A];
        case (op[5:3])
            3'd0: r = {1'b0, a} + operand;
            3'd1: r = {1'b0, a} + operand + cpu_carry;
            3'd2, 3'd7: r = {1'b0, a} - operand;
            3'd3: r = {1'b0, a} - operand - cpu_carry;
            3'd4: r = {1'b0, a & operand};
            3'd5: r = {1'b0, a ^ operand};
            default: r = {1'b0, a | operand};
        endcase
        cpu_carry = r[8];
        cpu_flags = r[7:0];
        if (op[5:3] != 3'd7) cpu_regs[c8008_pkg::REG_A] = r[7:0];
    endfunction

    function automatic void rotate_acc(input logic [7:0] op);
        logic [7:0] a;
        a = cpu_regs[c8008_pkg::REG_A];
        case (op)
            8'h02: begin cpu_regs[c8008_pkg::REG_A] = {a[6:0], a[7]}; cpu_carry = a[7]; end
            8'h0A: begin cpu_regs[c8008_pkg::REG_A] = {a[0], a[7:1]}; cpu_carry = a[0]; end
            8'h12: begin cpu_regs[c8008_pkg::REG_A] = {a[6:0], cpu_carry}; cpu_carry = a[7]; end
            8'h1A: begin cpu_regs[c8008_pkg::REG_A] = {cpu_carry, a[7:1]}; cpu_carry = a[0]; end
            default: ;
        endcase
    endfunction

    // Executes one beat on the testbench state and returns the result it must produce.
    function automatic t_outcome execute_instr(input t_instr t);
        t_outcome o;
        logic [7:0] op;
        logic [4:0] cls;
        logic [2:0] dst;
        logic [1:0] len;
        logic [15:0] cyc;
        o = '{default: '0};
        op = t.opcode;
        cyc = '0;
        if (t.command == 1'(CMD_INTERRUPT)) begin
            cpu_halt = 1'b0;
            push_stack();
            pc_stack[stack_top] = {6'd0, t.interrupt_vector};
        end else if (cpu_halt) begin
            cycle_count = '0;
            o.frame_end = 1'b1;
        end else begin
            cls = {op[7:6], op[2:0]};
            dst = op[5:3];
            if (cls == 5'd4 || cls == 5'd6) len = 2'd2;
            else if ((cls & 5'h19) == 5'h08) len = 2'd3;
            else len = 2'd1;
            o.bytes_used = len;
            pc_stack[stack_top] = pc_stack[stack_top] + len;
            if (op < 8'd2 || op == 8'hFF) begin
                cpu_halt = 1'b1;
                cycle_count = frame_size;
            end else begin
                case (cls)
                    5'h00, 5'h01: begin
                        cpu_regs[dst] = op[0] ? cpu_regs[dst] - 8'd1 : cpu_regs[dst] + 8'd1;
                        cpu_flags = cpu_regs[dst];
                        cyc = 5;
                    end
                    5'h02: begin rotate_acc(op); cyc = 5; end
                    5'h03, 5'h07: begin
                        if (cls == 5'h07 || condition_true(op)) pop_stack();
                        cyc = 4;
                    end
                    5'h04: begin arith_op(op, t.byte_two); cyc = 8; end
                    5'h05: begin
                        push_stack();
                        pc_stack[stack_top] = {8'd0, op[5:3], 3'd0};
                        cyc = 5;
                    end
                    5'h06: begin
                        cpu_regs[dst] = t.byte_two;
                        if (dst == 3'(c8008_pkg::REG_M)) begin
                            o.mem_write = 1'b1;
                            o.mem_write_address = hl_pair();
                            o.mem_write_data = t.byte_two;
                        end
                        cyc = 8;
                    end
                    5'h08, 5'h0A, 5'h0C, 5'h0E: begin
                        if (op[2] || condition_true(op)) begin
                            if (op[1]) push_stack();
                            pc_stack[stack_top] = {t.byte_three[5:0], t.byte_two};
                        end
                        cyc = 10;
                    end
                    5'h09, 5'h0B, 5'h0D, 5'h0F: begin
                        o.io_access = 1'b1;
                        o.io_port = op[5:1];
                        o.io_out_data = cpu_regs[c8008_pkg::REG_A];
                        cpu_regs[c8008_pkg::REG_A] = t.io_return;
                        cyc = 7;
                    end
                    default: begin
                        // The memory operand is loaded into the scratch first.
                        if (op[2:0] == 3'd7) cpu_regs[c8008_pkg::REG_M] = t.memory_at_hl;
                        if (cls < 5'h18) begin
                            arith_op(op, cpu_regs[op[2:0]]);
                        end else begin
                            cpu_regs[dst] = cpu_regs[op[2:0]];
                            if (dst == 3'(c8008_pkg::REG_M)) begin
                                o.mem_write = 1'b1;
                                o.mem_write_address = hl_pair();
                                o.mem_write_data = cpu_regs[c8008_pkg::REG_M];
                            end
                        end
                        cyc = 6;
                    end
                endcase
                cycle_count = cycle_count + cyc;
            end
            if (cycle_count >= frame_size) begin
                cycle_count = cycle_count - frame_size;
                o.frame_end = 1'b1;
            end
        end
        o.next_pc = pc_stack[stack_top];
        o.hl_address = hl_pair();
        o.halted = cpu_halt;
        return o;
    endfunction

    function automatic t_instr random_instr(input logic [7:0] op);
        t_instr t;
        t.command = 1'(CMD_EXECUTE);
        t.opcode = op;
        t.byte_two = 8'($urandom);
        t.byte_three = 8'($urandom);
        t.memory_at_hl = 8'($urandom);
        t.io_return = 8'($urandom);
        t.interrupt_vector = 8'($urandom);
        return t;
    endfunction

    // Predictions are made as the beat is launched; beats go in order, so the queue stays aligned.
    function automatic bit execute_instr_wrapped(input t_instr t);
        expected_outcomes.push_back(execute_instr(t));
        return 1'b1;
    endfunction

    // Driver: presents queued beats at the falling edge and holds them until taken.
    always @(negedge i_clk) begin
        t_instr t;
        if (i_rst_n) begin
            if (i_valid && o_ready_seen) begin
                beats_sent <= beats_sent + 1;
            end
            if ((!i_valid || o_ready_seen) && pending_instrs.size() > 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                t = pending_instrs.pop_front();
                void'(execute_instr_wrapped(t));
                i_valid <= 1'b1;
                i_command <= t.command;
                i_opcode <= t.opcode;
                i_byte_two <= t.byte_two;
                i_byte_three <= t.byte_three;
                i_memory_at_hl <= t.memory_at_hl;
                i_io_return <= t.io_return;
                i_interrupt_vector <= t.interrupt_vector;
            end else if (i_valid && o_ready_seen) begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) o_ready_seen <= i_valid && o_ready;

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result beat with no prediction waiting");
                error_count = error_count + 1;
            end else begin
                e = expected_outcomes.pop_front();
                beats_checked <= beats_checked + 1;
                if (o_frame_end) frame_ends <= frame_ends + 1;
                if (o_next_pc !== e.next_pc) begin
                    $error("next_pc expected %0h actual %0h", e.next_pc, o_next_pc);
                    error_count = error_count + 1;
                end
                if (o_hl_address !== e.hl_address) begin
                    $error("hl_address expected %0h actual %0h", e.hl_address, o_hl_address);
                    error_count = error_count + 1;
                end
                if (o_mem_write !== e.mem_write) begin
                    $error("mem_write expected %0h actual %0h", e.mem_write, o_mem_write);
                    error_count = error_count + 1;
                end
                if (o_mem_write_address !== e.mem_write_address) begin
                    $error("mem_write_address expected %0h actual %0h",
                           e.mem_write_address, o_mem_write_address);
                    error_count = error_count + 1;
                end
                if (o_mem_write_data !== e.mem_write_data) begin
                    $error("mem_write_data expected %0h actual %0h",
                           e.mem_write_data, o_mem_write_data);
                    error_count = error_count + 1;
                end
                if (o_io_access !== e.io_access) begin
                    $error("io_access expected %0h actual %0h", e.io_access, o_io_access);
                    error_count = error_count + 1;
                end
                if (o_io_port !== e.io_port) begin
                    $error("io_port expected %0h actual %0h", e.io_port, o_io_port);
                    error_count = error_count + 1;
                end
                if (o_io_out_data !== e.io_out_data) begin
                    $error("io_out_data expected %0h actual %0h", e.io_out_data, o_io_out_data);
                    error_count = error_count + 1;
                end
                if (o_bytes_used !== e.bytes_used) begin
                    $error("bytes_used expected %0h actual %0h", e.bytes_used, o_bytes_used);
                    error_count = error_count + 1;
                end
                if (o_halted !== e.halted) begin
                    $error("halted expected %0h actual %0h", e.halted, o_halted);
                    error_count = error_count + 1;
                end
                if (o_frame_end !== e.frame_end) begin
                    $error("frame_end expected %0h actual %0h", e.frame_end, o_frame_end);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Waits until the driver has launched everything and every result is back.
    task automatic drain_all();
        while (pending_instrs.size() > 0 || i_valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Writes the frame size while the core is idle, mirrored in the prediction.
    task automatic write_frame_size(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        frame_size = v;
    endtask

    // Mostly real programs: arithmetic, moves, calls and returns; few halts,
    // and interrupts to bring the core back out of halt.
    task automatic queue_random(input int unsigned n);
        t_instr t;
        logic [7:0] op;
        repeat (n) begin
            case ($urandom_range(9, 0))
                0: op = {2'b00, 3'($urandom), 3'($urandom_range(7, 2))};
                1, 2: op = {2'b10, 6'($urandom)};
                3, 4: op = {2'b11, 6'($urandom)};
                5: op = {2'b01, 6'($urandom)};
                6: op = {2'b00, 3'($urandom), 2'b10, 1'($urandom)};
                7: op = 8'($urandom);
                8: op = {2'b00, 3'($urandom), 3'($urandom_range(1, 0))};
                default: op = {2'b00, 3'($urandom), 3'b110};
            endcase
            // Halt rarely so most beats do real work.
            if ((op < 8'd2 || op == 8'hFF) && $urandom_range(3, 0) != 0) op = 8'hC0;
            t = random_instr(op);
            if ($urandom_range(19, 0) == 0) t.command = 1'(CMD_INTERRUPT);
            pending_instrs.push_back(t);
        end
    endtask

    initial begin
        t_instr t;
        logic [7:0] directed_ops [] = '{
            8'h06, 8'h0E, 8'h3E, 8'h3C, 8'h08, 8'h39, 8'h38, 8'h02, 8'h0A, 8'h12,
            8'h1A, 8'h22, 8'h04, 8'h3C, 8'hC7, 8'hF8, 8'h87, 8'hBF, 8'h44, 8'h46,
            8'h03, 8'h07, 8'h0D, 8'h41, 8'h7F, 8'h00, 8'hFF, 8'h01
        };
        for (int i = 0; i < 8; i++) cpu_regs[i] = '0;
        for (int i = 0; i < STACK_SLOTS; i++) pc_stack[i] = '0;
        cpu_carry = 0; cpu_flags = 0; cpu_halt = 0;
        stack_top = 0; cycle_count = 0; frame_size = c8008_pkg::FRAME_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: extreme field values, each opcode group, rotates
        // including an unused one, scratch inc/dec, compare, restart, call,
        // jump, I/O, halt while halted and an interrupt to leave halt.
        write_frame_size(16'd0);
        foreach (directed_ops[i]) begin
            t = random_instr(directed_ops[i]);
            if (i < 2) begin
                t.byte_two = 8'hFF; t.byte_three = 8'hFF; t.memory_at_hl = 8'hFF;
                t.io_return = 8'hFF; t.interrupt_vector = 8'hFF;
            end
            pending_instrs.push_back(t);
        end
        t = random_instr(8'h00);
        t.command = 1'(CMD_INTERRUPT);
        t.interrupt_vector = 8'hFF;
        pending_instrs.push_back(t);
        drain_all();

        // Phase one: sender idles rarely, receiver often; one long hold-off.
        write_frame_size(16'hFFFF);
        send_idle_pct = 19; recv_idle_pct = 69;
        queue_random(250);
        hold_off_cycles = 60;
        drain_all();

        write_frame_size(16'd17);
        send_idle_pct = 69; recv_idle_pct = 19;
        queue_random(250);
        drain_all();

        write_frame_size(16'd1);
        send_idle_pct = 0; recv_idle_pct = 0;
        queue_random(250);
        drain_all();

        $display("Sent %0d beats and checked %0d results (%0d frame ends) over four frame sizes,",
                 beats_sent, beats_checked, frame_ends);
        $display("with stalls on both channels and a long receiver hold-off.");
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule
